[hdl/bnms_pkg.sv]
`default_nettype none
package bnms_pkg;

	// field widths
	localparam int unsigned COORD_W   = 16;
	localparam int unsigned SCORE_W   = 16;
	localparam int unsigned THR_W     = 16;
	localparam int unsigned SPAN_W    = COORD_W + 1;
	localparam int unsigned AREA_W    = 33;
	localparam int unsigned UNION_W   = AREA_W + 1;
	localparam int unsigned PROD_W    = UNION_W + THR_W;
	localparam int unsigned CORNER_W  = 4 * COORD_W;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned IN_DATA_W = 80;
	localparam int unsigned OUT_DATA_W = 8;

	localparam int unsigned MAX_BOXES_DEF = 64;
	localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_PICK,
		ST_FETCH,
		ST_SUPP,
		ST_DRAIN,
		ST_EMIT
	} bnms_state_t;

	// valid flag and slot index travelling with an overlap test
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} bnms_tag_t;

	// inclusive span length, zero when inverted
	function automatic logic [SPAN_W-1:0] span_len(input logic [COORD_W-1:0] lo,
			input logic [COORD_W-1:0] hi);
		logic [SPAN_W-1:0] d;
		d = {1'b0, hi} - {1'b0, lo} + SPAN_W'(1);
		return (hi >= lo) ? d : '0;
	endfunction

endpackage
`default_nettype wire

[hdl/bnms_iou.sv]
`default_nettype none
// Pipelined overlap test: flags a box whose IoU with the picked box
// exceeds the threshold. Four register stages.
module bnms_iou (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bnms_pkg::bnms_tag_t           tag,
	input  wire logic [bnms_pkg::CORNER_W-1:0] corner_b,
	input  wire logic [bnms_pkg::AREA_W-1:0]   area_b,
	input  wire logic [bnms_pkg::CORNER_W-1:0] corner_i,
	input  wire logic [bnms_pkg::AREA_W-1:0]   area_i,
	input  wire logic [bnms_pkg::THR_W-1:0]    thr,
	output bnms_pkg::bnms_tag_t                kill,
	output logic                               busy
);
	import bnms_pkg::*;

	bnms_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [SPAN_W-1:0]  w_s1, h_s1;
	logic [UNION_W-1:0] sum_s1, sum_s2;
	logic [AREA_W-1:0]  inter_s2, inter_s3, inter_s4;
	logic [UNION_W-1:0] uni_s3;
	logic [PROD_W-1:0]  prod_s4;

	logic [COORD_W-1:0] lx, ly, hx, hy;
	logic [2*SPAN_W-1:0] wh;

	// intersection corners
	always_comb begin
		lx = (corner_b[15:0]  > corner_i[15:0])  ? corner_b[15:0]  : corner_i[15:0];
		ly = (corner_b[31:16] > corner_i[31:16]) ? corner_b[31:16] : corner_i[31:16];
		hx = (corner_b[47:32] < corner_i[47:32]) ? corner_b[47:32] : corner_i[47:32];
		hy = (corner_b[63:48] < corner_i[63:48]) ? corner_b[63:48] : corner_i[63:48];
		wh = w_s1 * h_s1;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		w_s1     <= span_len(lx, hx);
		h_s1     <= span_len(ly, hy);
		sum_s1   <= UNION_W'(area_b) + UNION_W'(area_i);
		inter_s2 <= wh[AREA_W-1:0];
		sum_s2   <= sum_s1;
		uni_s3   <= sum_s2 - UNION_W'(inter_s2);
		inter_s3 <= inter_s2;
		prod_s4  <= PROD_W'(thr) * PROD_W'(uni_s3);
		inter_s4 <= inter_s3;
	end

	always_comb begin
		kill.idx = tag_s4.idx;
		kill.vld = tag_s4.vld && ({1'b0, inter_s4, 16'b0} > prod_s4);
		busy     = tag_s1.vld | tag_s2.vld | tag_s3.vld | tag_s4.vld;
	end

endmodule
`default_nettype wire

[hdl/box_non_max_suppression.sv]
`default_nettype none
// Greedy box non-maximum suppression. Boxes stream in at one per cycle and
// are stored in slots 0, 1, 2, ... (boxes beyond MAX_BOXES are dropped); the
// box with tlast starts suppression and s_axis_tready stays low until the
// last picked index (m_axis_tlast) has been taken. Each pick takes, for N
// loaded boxes, one pass over the score memory to find the best alive box,
// a fetch of its corners, one pass over the corner and area memories
// through a four-stage overlap pipeline, then the output transaction. The
// box memories have a single read port, so these steps run one after another.
// No clearing pass is needed after reset.
module box_non_max_suppression #(
	parameter int unsigned MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bnms_pkg::THR_W-1:0]       cfg_wdata,    // overlap_threshold
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// box_x1, box_y1, box_x2, box_y2, box_score
	input  wire logic [bnms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  wire logic                             s_axis_tlast,  // last_box
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [bnms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // picked_index, zero pad
	output logic                                  m_axis_tlast   // last_pick
);
	import bnms_pkg::*;

	localparam int unsigned IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int unsigned CW = $clog2(MAX_BOXES + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_BOXES);

	bnms_state_t state_q, state_d;

	logic [THR_W-1:0]     thr_q;
	logic [CW-1:0]        box_cnt_q;
	logic [CW-1:0]        cnt_q;
	logic [MAX_BOXES-1:0] alive_q;
	logic [IW-1:0]        best_q;
	logic [SCORE_W-1:0]   best_score_q;
	logic                 found_q;
	logic [CORNER_W-1:0]  corner_b_q;
	logic [AREA_W-1:0]    area_b_q;
	logic                 rv_s1;
	logic [IW-1:0]        ridx_s1;

	// box memories
	logic [CORNER_W-1:0] corner_mem [MAX_BOXES];
	logic [SCORE_W-1:0]  score_mem  [MAX_BOXES];
	logic [AREA_W-1:0]   area_mem   [MAX_BOXES];
	logic [CORNER_W-1:0] corner_rd;
	logic [SCORE_W-1:0]  score_rd;
	logic [AREA_W-1:0]   area_rd;

	logic [IW-1:0] rd_addr;
	logic          issue;
	logic          in_acc, out_acc, wr_en;
	logic [SPAN_W-1:0]   wl, hl;
	logic [2*SPAN_W-1:0] area_in;
	logic                iou_busy;
	bnms_tag_t           iou_tag, kill;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign wr_en   = in_acc && (box_cnt_q != FULL);
	assign issue   = (cnt_q != box_cnt_q);

	// area of the incoming box
	always_comb begin
		wl      = span_len(s_axis_tdata[15:0],  s_axis_tdata[47:32]);
		hl      = span_len(s_axis_tdata[31:16], s_axis_tdata[63:48]);
		area_in = wl * hl;
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			corner_mem[box_cnt_q[IW-1:0]] <= s_axis_tdata[63:0];
			score_mem[box_cnt_q[IW-1:0]]  <= s_axis_tdata[79:64];
			area_mem[box_cnt_q[IW-1:0]]   <= area_in[AREA_W-1:0];
		end
		corner_rd <= corner_mem[rd_addr];
		score_rd  <= score_mem[rd_addr];
		area_rd   <= area_mem[rd_addr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else         state_q <= state_d;
	end

	// next state and outputs
	always_comb begin
		state_d       = state_q;
		rd_addr       = cnt_q[IW-1:0];
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (in_acc && s_axis_tlast) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!issue && !rv_s1) state_d = ST_PICK;
			end
			ST_PICK: begin
				rd_addr = best_q;
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_SUPP;
			end
			ST_SUPP: begin
				if (!issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!rv_s1 && !iou_busy) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) state_d = (alive_q == '0) ? ST_LOAD : ST_SCAN;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			box_cnt_q <= '0;
			cnt_q     <= '0;
			alive_q   <= '0;
			found_q   <= 1'b0;
			rv_s1     <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			rv_s1 <= 1'b0;
			if (wr_en) begin
				box_cnt_q <= box_cnt_q + CW'(1);
				alive_q[box_cnt_q[IW-1:0]] <= 1'b1;
			end
			if (in_acc && s_axis_tlast) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if ((state_q == ST_SCAN || state_q == ST_SUPP) && issue) begin
				cnt_q <= cnt_q + CW'(1);
				rv_s1 <= (state_q == ST_SCAN) || alive_q[cnt_q[IW-1:0]];
			end
			if (state_q == ST_SCAN && rv_s1 && alive_q[ridx_s1] &&
					(!found_q || score_rd >= best_score_q))
				found_q <= 1'b1;
			if (state_q == ST_PICK) begin
				alive_q[best_q] <= 1'b0;
				cnt_q           <= '0;
			end
			if (kill.vld) alive_q[kill.idx[IW-1:0]] <= 1'b0;
			if (state_q == ST_EMIT && out_acc) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				if (alive_q == '0) box_cnt_q <= '0;
			end
		end
	end

	// best candidate and picked box payload
	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q[IW-1:0];
		if (state_q == ST_SCAN && rv_s1 && alive_q[ridx_s1] &&
				(!found_q || score_rd >= best_score_q)) begin
			best_q       <= ridx_s1;
			best_score_q <= score_rd;
		end
		if (state_q == ST_FETCH) begin
			corner_b_q <= corner_rd;
			area_b_q   <= area_rd;
		end
	end

	always_comb begin
		iou_tag.vld = rv_s1 && (state_q == ST_SUPP || state_q == ST_DRAIN);
		iou_tag.idx = IDX_W'(ridx_s1);
	end

	bnms_iou u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (iou_tag),
		.corner_b (corner_b_q),
		.area_b   (area_b_q),
		.corner_i (corner_rd),
		.area_i   (area_rd),
		.thr      (thr_q),
		.kill     (kill),
		.busy     (iou_busy)
	);

	assign m_axis_tdata = OUT_DATA_W'(best_q);
	assign m_axis_tlast = (alive_q == '0);

endmodule
`default_nettype wire

[hdl/bnms_checker.sv]
`default_nettype none
// Port-level checks for the suppression block.
module bnms_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled result changed");

	// loading and emitting never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");

	// last box closes the input until the run ends
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input open after last box");

	// final pick reopens the input
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("input not reopened after last pick");

endmodule

bind box_non_max_suppression bnms_checker u_bnms_checker (.*);
`default_nettype wire
